// ===== rtl/core/smeu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smeu_pkg
// Shared types and constants for the stack machine execute unit.
// ----------------------------------------------------------------------------
package smeu_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int NUM_REGS_DEF    = 4;
  localparam int MEM_WORDS_DEF   = 256;

  typedef enum logic [3:0] {
    OP_PUSH = 4'd0, OP_POP = 4'd1, OP_ADD = 4'd2, OP_SUB = 4'd3,
    OP_MUL = 4'd4, OP_DIV = 4'd5, OP_SQRT = 4'd6, OP_OUT = 4'd7,
    OP_IN = 4'd8, OP_JMP = 4'd9, OP_JA = 4'd10, OP_JEQ = 4'd11,
    OP_JB = 4'd12, OP_JAE = 4'd13, OP_JBE = 4'd14, OP_JNE = 4'd15
  } op_t;

  localparam logic [1:0] MODE_IMM = 2'd0;
  localparam logic [1:0] MODE_REG = 2'd1;
  localparam logic [1:0] MODE_DIR = 2'd2;
  localparam logic [1:0] MODE_IND = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNDER   = 3'd1;
  localparam logic [2:0] ST_OVER    = 3'd2;
  localparam logic [2:0] ST_DIVZERO = 3'd3;
  localparam logic [2:0] ST_NEGSQRT = 3'd4;
  localparam logic [2:0] ST_RANGE   = 3'd5;

  // Classified request from front to back.
  typedef struct packed {
    op_t         op;
    logic [1:0]  mode;
    logic [31:0] immediate;
    logic [1:0]  reg_index;
    logic [7:0]  mem_address;
    logic [15:0] jump_target;
    logic [31:0] in_value;
    logic        is_push;
    logic        is_pop;
    logic        is_bin;
    logic        is_cjmp;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        out_valid;
    logic [31:0] out_value;
    logic        jump_taken;
    logic [15:0] next_target;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_SRC, S_EXEC, S_MUL, S_DIV, S_SQRT, S_WB, S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/smeu_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smeu_in_if / smeu_out_if
// Valid/ready channels for instruction requests and results.
// ----------------------------------------------------------------------------
interface smeu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [1:0]  mode;
  logic [31:0] immediate;
  logic [1:0]  reg_index;
  logic [7:0]  mem_address;
  logic [15:0] jump_target;
  logic [31:0] in_value;
  modport source (output valid, action, mode, immediate, reg_index, mem_address,
                  jump_target, in_value, input ready);
  modport sink (input valid, action, mode, immediate, reg_index, mem_address,
                jump_target, in_value, output ready);
endinterface

interface smeu_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        out_valid;
  logic [31:0] out_value;
  logic        jump_taken;
  logic [15:0] next_target;
  modport source (output valid, status, out_valid, out_value, jump_taken,
                  next_target, input ready);
  modport sink (input valid, status, out_valid, out_value, jump_taken,
                next_target, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/smeu_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smeu_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module smeu_front
  import smeu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  smeu_in_if.sink   in_ch,
  output req_t      req,
  output logic      req_valid,
  input  wire logic req_take
);

  req_t       q [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  req_t       cls;
  logic       push_en;

  always_comb begin
    cls.op          = op_t'(in_ch.action);
    cls.mode        = in_ch.mode;
    cls.immediate   = in_ch.immediate;
    cls.reg_index   = in_ch.reg_index;
    cls.mem_address = in_ch.mem_address;
    cls.jump_target = in_ch.jump_target;
    cls.in_value    = in_ch.in_value;
    cls.is_push     = in_ch.action == OP_PUSH || in_ch.action == OP_IN;
    cls.is_pop      = in_ch.action == OP_POP || in_ch.action == OP_OUT;
    cls.is_bin      = in_ch.action inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV};
    cls.is_cjmp     = in_ch.action >= OP_JA;
  end

  assign in_ch.ready = count != 2'd2;
  assign push_en     = in_ch.valid && in_ch.ready;
  assign req_valid   = count != 2'd0;
  assign req         = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_en) q[wr_ptr] <= cls;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_en) wr_ptr <= ~wr_ptr;
      if (req_take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push_en} - {1'b0, req_take};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/smeu_divsqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smeu_divsqrt
// Iterative unit: signed truncating divide or integer square root, 2 bits
// of quotient or 1 root bit a cycle.
// ----------------------------------------------------------------------------
module smeu_divsqrt
  import smeu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        is_sqrt,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             done,
  output logic [31:0]      result
);

  logic        busy, sq, neg;
  logic [4:0]  cnt;
  logic [31:0] rem_q, div_b, quo, xr, res, bitv;
  logic [32:0] r1, r2;
  logic [31:0] q1, rm1;
  logic [31:0] ua, ub;

  assign ua = a[31] ? 32'd0 - a : a;
  assign ub = b[31] ? 32'd0 - b : b;

  // Two restoring division steps; rem_q holds {remainder-in-progress shifted}.
  logic [63:0] pr, pr1, pr2;
  always_comb begin
    pr  = {rem_q, quo};
    pr1 = pr << 1;
    r1  = {1'b0, pr1[63:32]} - {1'b0, div_b};
    if (!r1[32]) pr1 = {r1[31:0], pr1[31:1], 1'b1};
    pr2 = pr1 << 1;
    r2  = {1'b0, pr2[63:32]} - {1'b0, div_b};
    if (!r2[32]) pr2 = {r2[31:0], pr2[31:1], 1'b1};
    q1  = pr2[31:0];
    rm1 = pr2[63:32];
  end

  logic [31:0] rb, sres;
  logic        ge;
  assign rb   = res + bitv;
  assign ge   = xr >= rb;
  assign sres = ge ? (res >> 1) + bitv : res >> 1;

  assign done = busy && cnt == 5'd0 && !start;

  always_comb begin
    if (sq) result = res;
    else result = neg ? 32'd0 - quo : quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      sq    <= is_sqrt;
      cnt   <= is_sqrt ? 5'd16 : 5'd16;
      rem_q <= 32'd0;
      quo   <= ua;
      div_b <= ub;
      neg   <= a[31] ^ b[31];
      xr    <= a;
      res   <= 32'd0;
      bitv  <= 32'h4000_0000;
    end else if (busy && cnt != 5'd0) begin
      cnt <= cnt - 5'd1;
      if (sq) begin
        if (ge) xr <= xr - rb;
        res  <= sres;
        bitv <= bitv >> 2;
      end else begin
        quo   <= q1;
        rem_q <= rm1;
      end
    end else if (busy) begin
      busy <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/smeu_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smeu_back
// Executes requests against the stack, registers and data memory.
// ----------------------------------------------------------------------------
module smeu_back
  import smeu_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int NUM_REGS    = NUM_REGS_DEF,
  parameter int MEM_WORDS   = MEM_WORDS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire req_t  req,
  input  wire logic  req_valid,
  output logic       req_take,
  smeu_out_if.source out_ch
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int MAW = $clog2(MEM_WORDS);
  localparam int RIW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic [31:0] stk [STACK_DEPTH];
  logic [31:0] mem [MEM_WORDS];
  logic [31:0] regs [NUM_REGS];

  state_t      state, state_next;
  logic [SPW-1:0] sp;
  logic [MAW:0]   clr_addr;
  logic        clearing;
  req_t        r;
  logic [31:0] top, nxt, src, wr_val, stk_q, mem_q;
  logic [63:0] prod;
  logic [2:0]  st;
  logic        jt;
  logic [MAW-1:0] maddr;
  logic        maddr_ok, reg_ok;
  logic [31:0] regv;
  logic        ds_start, ds_done;
  logic [31:0] ds_res;
  res_t        res;
  logic        out_full;

  // stack read address and memory address steering
  logic [SAW-1:0] stk_ra;
  always_comb begin
    stk_ra = SAW'(sp - SPW'(1));
    if (state == S_RD2) stk_ra = SAW'(sp - SPW'(2));
  end

  assign reg_ok = 32'(r.reg_index) < NUM_REGS;
  assign regv   = reg_ok ? regs[RIW'(r.reg_index)] : 32'd0;
  always_comb begin
    maddr_ok = 1'b0;
    maddr    = '0;
    if (r.mode == MODE_DIR) begin
      maddr_ok = 32'(r.mem_address) < MEM_WORDS;
      maddr    = MAW'(r.mem_address);
    end else if (reg_ok) begin
      maddr_ok = !regv[31] && regv < 32'(MEM_WORDS);
      maddr    = MAW'(regv);
    end
  end

  assign clearing = !clr_addr[MAW];
  assign req_take = state == S_IDLE && req_valid && !clearing;
  assign out_full = out_ch.valid && !out_ch.ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (req_take) state_next = S_RD1;
      S_RD1:  state_next = S_RD2;
      S_RD2:  state_next = S_SRC;
      S_SRC:  state_next = S_EXEC;
      S_EXEC: begin
        if (st != ST_OK) state_next = S_DONE;
        else if (r.op == OP_MUL) state_next = S_MUL;
        else if (r.op == OP_DIV || r.op == OP_SQRT) state_next = S_DIV;
        else state_next = S_WB;
      end
      S_MUL:  state_next = S_WB;
      S_DIV:  if (ds_done) state_next = S_WB;
      S_WB:   state_next = S_DONE;
      S_DONE: if (!out_full) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // error check, evaluated in S_EXEC
  always_comb begin
    st = ST_OK;
    jt = 1'b0;
    if (r.is_push) begin
      if (sp >= SPW'(STACK_DEPTH)) st = ST_OVER;
      else if (r.op == OP_PUSH && r.mode == MODE_REG && !reg_ok) st = ST_RANGE;
      else if (r.op == OP_PUSH && r.mode[1] && !maddr_ok) st = ST_RANGE;
    end else if (r.is_pop) begin
      if (sp < SPW'(1)) st = ST_UNDER;
      else if (r.op == OP_POP && r.mode == MODE_REG && !reg_ok) st = ST_RANGE;
      else if (r.op == OP_POP && r.mode[1] && !maddr_ok) st = ST_RANGE;
    end else if (r.is_bin) begin
      if (sp < SPW'(2)) st = ST_UNDER;
      else if (r.op == OP_DIV && top == 32'd0) st = ST_DIVZERO;
    end else if (r.op == OP_SQRT) begin
      if (sp < SPW'(1)) st = ST_UNDER;
      else if (top[31]) st = ST_NEGSQRT;
    end else if (r.is_cjmp) begin
      if (sp < SPW'(2)) st = ST_UNDER;
      else begin
        case (r.op)
          OP_JA:   jt = $signed(top) >  $signed(nxt);
          OP_JEQ:  jt = top == nxt;
          OP_JB:   jt = $signed(top) <  $signed(nxt);
          OP_JAE:  jt = $signed(top) >= $signed(nxt);
          OP_JBE:  jt = $signed(top) <= $signed(nxt);
          default: jt = top != nxt;
        endcase
      end
    end else begin
      jt = 1'b1;
    end
  end

  assign ds_start = state == S_EXEC && st == ST_OK && (r.op == OP_DIV || r.op == OP_SQRT);

  smeu_divsqrt u_divsqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (ds_start),
    .is_sqrt (r.op == OP_SQRT),
    .a       (r.op == OP_SQRT ? top : nxt),
    .b       (top),
    .done    (ds_done),
    .result  (ds_res)
  );

  always_comb begin
    case (r.op)
      OP_ADD:  wr_val = nxt + top;
      OP_SUB:  wr_val = nxt - top;
      OP_MUL:  wr_val = prod[31:0];
      OP_DIV:  wr_val = ds_res;
      OP_SQRT: wr_val = ds_res;
      default: wr_val = src;
    endcase
  end

  // sp has already moved in S_EXEC, so the written slot is the new top
  always_ff @(posedge clk) begin
    stk_q <= stk[stk_ra];
    mem_q <= mem[maddr];
    if (clearing) mem[clr_addr[MAW-1:0]] <= 32'd0;
    else if (state == S_WB && r.op == OP_POP && r.mode[1]) mem[maddr] <= top;
    if (state == S_WB) begin
      if (r.is_push) stk[SAW'(sp - SPW'(1))] <= src;
      else if (r.is_bin) stk[SAW'(sp - SPW'(1))] <= wr_val;
      else if (r.op == OP_SQRT) stk[SAW'(sp - SPW'(1))] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (req_take) r <= req;
      S_RD2:  top <= stk_q;
      S_SRC: begin
        nxt <= stk_q;
        if (r.op == OP_IN) src <= r.in_value;
        else if (r.mode == MODE_IMM) src <= r.immediate;
        else if (r.mode == MODE_REG) src <= regv;
        else src <= mem_q;
      end
      S_MUL:  prod <= nxt * top;
      default: ;
    endcase
    if (state == S_EXEC) begin
      res.status      <= st;
      res.out_valid   <= st == ST_OK && r.op == OP_OUT;
      res.out_value   <= (st == ST_OK && r.op == OP_OUT) ? top : 32'd0;
      res.jump_taken  <= st == ST_OK && jt;
      res.next_target <= (st == ST_OK && jt) ? r.jump_target : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sp       <= '0;
      clr_addr <= '0;
      out_ch.valid <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= 32'd0;
    end else begin
      state <= state_next;
      if (clearing) clr_addr <= clr_addr + 1'b1;
      if (state == S_DONE && !out_full) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      if (state == S_EXEC && st == ST_OK) begin
        if (r.is_push) sp <= sp + SPW'(1);
        else if (r.is_pop || r.is_bin) sp <= sp - SPW'(1);
        else if (r.is_cjmp) sp <= sp - SPW'(2);
        if (r.op == OP_POP && r.mode == MODE_REG) regs[RIW'(r.reg_index)] <= top;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && !out_full) begin
      out_ch.status      <= res.status;
      out_ch.out_valid   <= res.out_valid;
      out_ch.out_value   <= res.out_value;
      out_ch.jump_taken  <= res.jump_taken;
      out_ch.next_target <= res.next_target;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/stack_machine_execute_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Executes decoded stack-machine instructions, one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one decoded instruction per request; out_ch returns one
//   result (status, out value, jump info) per request, in order.
//   A two-entry queue parts the front from the execute sequencer, so
//   requests are taken while a result waits on out_ch.
//   Each request passes through the sequencer's stack read, execute and
//   write-back steps; mul adds a multiply step, div and sqrt wait on the
//   16-step divide/root unit, and a request that ends in an error skips
//   write-back. One request is executed at a time.
//   Reset: stack pointer and registers clear at once; a clearing pass
//   then zeroes every word of the data memory before the first
//   request executes (requests still enter the queue).
//   A stalled out_ch holds its result; the sequencer waits to post the
//   next one and the queue fills, then in_ch ready drops.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit
  import smeu_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int NUM_REGS    = NUM_REGS_DEF,
  parameter int MEM_WORDS   = MEM_WORDS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  smeu_in_if.sink    in_ch,
  smeu_out_if.source out_ch
);

  req_t req;
  logic req_valid, req_take;

  smeu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .req       (req),
    .req_valid (req_valid),
    .req_take  (req_take)
  );

  smeu_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .NUM_REGS    (NUM_REGS),
    .MEM_WORDS   (MEM_WORDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_take  (req_take),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
